[hw/rtl/mfd_pkg.sv]
`timescale 1ns / 1ps

package mfd_pkg;

   // Motor table geometry
   localparam int MOTOR_SLOTS = 8;
   localparam int SLOT_W      = 3;
   localparam int LIMIT_W     = 4;

   // Feedback decoding
   localparam int ANGLE_W     = 16;
   localparam int TURNS_W     = 16;
   localparam int FRAMES_W    = 32;
   localparam int CMD_W       = 14;
   localparam int TOTAL_W     = 30;
   localparam int HALF_TURN   = 4096;
   localparam int TURN_SHIFT  = 13;     // one full turn is 8192 counts

   // Reciprocal of five: n * 52429 >> 18 equals n / 5 for n up to 2**16
   localparam logic [16:0] RECIP5       = 17'd52429;
   localparam int          RECIP5_SHIFT = 18;

   // Packed table entry: previous angle, turns, frame count
   localparam int ENTRY_W = ANGLE_W + TURNS_W + FRAMES_W;

   // Configuration registers
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_FRAME_ID = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_MOTORS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_OFFSET   = 2'd2;

   localparam logic [10:0]        BASE_FRAME_ID_RESET = 11'd513;
   localparam logic [LIMIT_W-1:0] ACTIVE_MOTORS_RESET = 4'd8;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_LOOKUP = 2'b10
   } state_type;

   typedef struct packed {
      logic [ANGLE_W-1:0]  prev_angle;
      logic [TURNS_W-1:0]  turns;
      logic [FRAMES_W-1:0] frames;
   } entry_type;

endpackage

[hw/rtl/mfd_ram.sv]
`timescale 1ns / 1ps

module mfd_ram #(
   parameter int WIDTH  = 64,
   parameter int DEPTH  = 8,
   parameter int ADDR_W = 3
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[hw/rtl/motor_feedback_multiturn_decoder.sv]
`timescale 1ns / 1ps
// Channel   | Ports                                   | Handshake
// ----------+-----------------------------------------+-------------------------------
// request   | req_frame_id, req_byte0..req_byte6      | taken when start & !busy
// response  | rsp_motor_index .. rsp_message_count    | rsp_valid, one cycle, no stall
// csr       | csr_we, csr_index, csr_wdata            | written when csr_we is high
//
// A frame in the motor window is handled thus: the accept cycle reads the motor's
// entry from the table RAM, the lookup cycle (busy high) updates and writes it back,
// and the response shows in the cycle after. A new item can be taken while that
// response is on the ports, but not in the lookup cycle, where the single RAM
// read-modify-write per item holds busy high. Frames outside the window leave
// busy low and give no response. Synchronous reset restores the registers and
// marks every table entry as zero through per-entry valid bits; the receiver cannot
// stall the response.

module motor_feedback_multiturn_decoder
   import mfd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       start,
   output logic                       busy,
   input  logic [10:0]                req_frame_id,
   input  logic [7:0]                 req_byte0,
   input  logic [7:0]                 req_byte1,
   input  logic [7:0]                 req_byte2,
   input  logic [7:0]                 req_byte3,
   input  logic [7:0]                 req_byte4,
   input  logic [7:0]                 req_byte5,
   input  logic [7:0]                 req_byte6,

   output logic                       rsp_valid,
   output logic [SLOT_W-1:0]          rsp_motor_index,
   output logic [ANGLE_W-1:0]         rsp_angle_now,
   output logic signed [15:0]         rsp_measured_current,
   output logic signed [CMD_W-1:0]    rsp_commanded_current,
   output logic [7:0]                 rsp_hall_state,
   output logic signed [TURNS_W-1:0]  rsp_turn_count,
   output logic signed [TOTAL_W-1:0]  rsp_total_position,
   output logic [FRAMES_W-1:0]        rsp_message_count,

   input  logic                       csr_we,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   // Configuration registers
   logic [10:0]         base_id_ff;
   logic [LIMIT_W-1:0]  active_ff;
   logic [15:0]         offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_id_ff <= BASE_FRAME_ID_RESET;
         active_ff  <= ACTIVE_MOTORS_RESET;
         offset_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BASE_FRAME_ID: base_id_ff <= csr_wdata[10:0];
            CSR_ACTIVE_MOTORS: active_ff  <= csr_wdata[LIMIT_W-1:0];
            CSR_ZERO_OFFSET:   offset_ff  <= csr_wdata;
            default:           ; // drop writes beyond the register list
         endcase
      end
   end

   // Window check on the incoming identifier
   logic [11:0]        id_diff;
   logic [LIMIT_W-1:0] limit;
   logic               in_window;
   logic               accept;

   assign id_diff = {1'b0, req_frame_id} - {1'b0, base_id_ff};
   // clamp the motor count to the table depth
   assign limit   = (active_ff < LIMIT_W'(MOTOR_SLOTS)) ? active_ff : LIMIT_W'(MOTOR_SLOTS);
   assign in_window = !id_diff[11] && (id_diff[10:0] < {{(11-LIMIT_W){1'b0}}, limit});

   state_type state_ff, state_in;
   assign busy   = (state_ff == ST_LOOKUP);
   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept && in_window) state_in = ST_LOOKUP;
         ST_LOOKUP: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Commanded word divided by minus five: magnitude times the reciprocal,
   // then sign flipped so the quotient truncates toward zero.
   logic signed [15:0] cmd_word;
   logic [16:0]        cmd_mag;
   logic [33:0]        cmd_prod;
   logic [CMD_W-1:0]   cmd_q;

   assign cmd_word = signed'({req_byte4, req_byte5});
   assign cmd_mag  = cmd_word[15] ? (17'd0 - {1'b1, cmd_word}) : {1'b0, cmd_word};
   assign cmd_prod = {17'd0, cmd_mag} * {17'd0, RECIP5};
   assign cmd_q    = cmd_prod[RECIP5_SHIFT +: CMD_W];

   // Hold the item's decoded fields over the lookup cycle
   logic [SLOT_W-1:0]       slot_ff;
   logic [ANGLE_W-1:0]      angle_ff;
   logic [15:0]             current_ff;
   logic signed [CMD_W-1:0] cmd_ff;
   logic [7:0]              hall_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff    <= id_diff[SLOT_W-1:0];
         angle_ff   <= {req_byte0, req_byte1};
         current_ff <= {req_byte2, req_byte3};
         cmd_ff     <= cmd_word[15] ? signed'(cmd_q) : signed'(CMD_W'(0) - cmd_q);
         hall_ff    <= req_byte6;
      end
   end

   // Motor table: one RAM, entries valid once written since reset
   logic [MOTOR_SLOTS-1:0] valid_ff;
   logic [ENTRY_W-1:0]     ram_rdata;
   entry_type              entry_old;
   entry_type              entry_new;
   logic                   table_we;

   assign table_we = busy;

   mfd_ram #(
      .WIDTH  (ENTRY_W),
      .DEPTH  (MOTOR_SLOTS),
      .ADDR_W (SLOT_W)
   ) u_table (
      .clock (clock),
      .we    (table_we),
      .waddr (slot_ff),
      .wdata (entry_new),
      .raddr (id_diff[SLOT_W-1:0]),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (table_we) begin
         valid_ff[slot_ff] <= 1'b1;
      end
   end

   // an entry never written since reset reads as all zero
   assign entry_old = valid_ff[slot_ff] ? entry_type'(ram_rdata) : '0;

   // Turn tracking: a jump of more than half a turn counts one turn
   logic signed [16:0]        angle_step;
   logic signed [TURNS_W-1:0] turns_old;
   logic signed [TURNS_W-1:0] turns_new;
   logic signed [30:0]        total_sum;

   assign angle_step = signed'({1'b0, angle_ff}) - signed'({1'b0, entry_old.prev_angle});
   assign turns_old  = signed'(entry_old.turns);

   always_comb begin
      turns_new = turns_old;
      if (angle_step > 17'sd4096) begin
         // wrapped backward through zero
         if (turns_old != {1'b1, {(TURNS_W-1){1'b0}}}) turns_new = turns_old - 16'sd1;
      end else if (angle_step < -17'sd4096) begin
         // wrapped forward through zero
         if (turns_old != {1'b0, {(TURNS_W-1){1'b1}}}) turns_new = turns_old + 16'sd1;
      end
   end

   assign total_sum = (31'(turns_new) <<< TURN_SHIFT)
                    + signed'({15'd0, angle_ff})
                    - signed'({15'd0, offset_ff});

   always_comb begin
      entry_new.prev_angle = angle_ff;
      entry_new.turns      = turns_new;
      entry_new.frames     = entry_old.frames + 32'd1;
   end

   // Response register: the receiver takes it in the one cycle it is shown
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= busy;
      end
   end

   always_ff @(posedge clock) begin
      if (busy) begin
         rsp_motor_index       <= slot_ff;
         rsp_angle_now         <= angle_ff;
         rsp_measured_current  <= signed'(current_ff);
         rsp_commanded_current <= cmd_ff;
         rsp_hall_state        <= hall_ff;
         rsp_turn_count        <= turns_new;
         rsp_total_position    <= total_sum[TOTAL_W-1:0];
         rsp_message_count     <= entry_new.frames;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[hw/rtl/mfd_checker.sv]
`timescale 1ns / 1ps

module mfd_checker (
   input logic clock,
   input logic reset,
   input logic busy,
   input logic rsp_valid
);

   // lookup lasts exactly one cycle
   a_busy_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy) else $error("busy held past one cycle");

   // every lookup yields a response in the next cycle
   a_busy_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_valid) else $error("lookup without response");

   // no response without a lookup before it
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("response without lookup");

   // responses never come back to back
   a_rsp_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("back-to-back responses");

   // reset clears control
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> (!busy && !rsp_valid)) else $error("control not cleared by reset");

endmodule

bind motor_feedback_multiturn_decoder mfd_checker u_mfd_checker (
   .clock     (clock),
   .reset     (reset),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);

[test/tb_motor_feedback_multiturn_decoder.sv]
`timescale 1ns / 1ps

module tb_motor_feedback_multiturn_decoder;
   import mfd_pkg::*;

   // Quiet cycles allowed before the run is declared hung. The longest legal
   // quiet stretch is the largest sender gap plus a short pipeline tail.
   localparam int STALL_LIMIT   = 2000;
   // Cycles to hold off after the last response before a register write or
   // the final verdict. A frame passes lookup and the response register.
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_HITS    = 60;
   localparam int PHASE_CAP     = 110;
   // Two motors, interleaved, each stepped just past half a turn per frame
   // so that the turn counts keep running away from zero.
   localparam int SWEEP_FRAMES  = 400;
   localparam int MAX_SHOWN     = 40;

   // One received bus frame; byte order follows the wire (angle high first)
   typedef struct packed {
      logic [10:0] id;
      logic [15:0] angle;
      logic [15:0] current;
      logic [15:0] command;
      logic [7:0]  hall;
   } frame_t;

   typedef struct packed {
      logic [SLOT_W-1:0]   slot;
      logic [ANGLE_W-1:0]  angle;
      logic [15:0]         current;
      logic [CMD_W-1:0]    command;
      logic [7:0]          hall;
      logic [TURNS_W-1:0]  turns;
      logic [TOTAL_W-1:0]  position;
      logic [FRAMES_W-1:0] count;
   } feedback_t;

   // Directed row: pinned rows carry a hand-written response (or none);
   // the rest are checked against the decoder model below.
   typedef struct packed {
      frame_t    frame;
      logic      pinned;
      logic      hit;
      feedback_t want;
   } vector_t;

   // Rows run at the reset settings: base 513, eight motors, no offset.
   localparam vector_t DIRECTED_ROWS [20] = '{
      // first frame of motor 0, all zero
      '{'{11'd513, 16'h0000, 16'h0000, 16'h0000, 8'h00}, 1'b1, 1'b1,
        '{3'd0, 16'h0000, 16'h0000, 14'h0000, 8'h00, 16'h0000, 30'd0, 32'd1}},
      // one below the window, one past the last motor
      '{'{11'd512, 16'h1234, 16'h5678, 16'h9abc, 8'hde}, 1'b1, 1'b0, '0},
      '{'{11'd521, 16'hffff, 16'hffff, 16'hffff, 8'hff}, 1'b1, 1'b0, '0},
      // first frame of motor 7 at full angle: jump up from zero, turns -1
      '{'{11'd520, 16'hffff, 16'h7fff, 16'h8000, 8'hff}, 1'b1, 1'b1,
        '{3'd7, 16'hffff, 16'h7fff, 14'h1999, 8'hff, 16'hffff, 30'd57343, 32'd1}},
      // wrap back to zero: turns return to 0, most positive command word
      '{'{11'd520, 16'h0000, 16'h8000, 16'h7fff, 8'h00}, 1'b1, 1'b1,
        '{3'd7, 16'h0000, 16'h8000, 14'h2667, 8'h00, 16'h0000, 30'd0, 32'd2}},
      // identifier extremes, both outside the window
      '{'{11'd0,    16'hffff, 16'hffff, 16'hffff, 8'hff}, 1'b1, 1'b0, '0},
      '{'{11'd2047, 16'h0000, 16'h0000, 16'h0000, 8'h00}, 1'b1, 1'b0, '0},
      // turn threshold: exactly half a turn counts nothing, one more counts
      '{'{11'd514, 16'h1000, 16'h1234, 16'hffff, 8'h5a}, 1'b0, 1'b0, '0},
      '{'{11'd514, 16'h0000, 16'hedcb, 16'h0005, 8'ha5}, 1'b0, 1'b0, '0},
      '{'{11'd514, 16'h2001, 16'h0001, 16'hfffb, 8'h01}, 1'b0, 1'b0, '0},
      '{'{11'd514, 16'h1000, 16'hffff, 16'h0004, 8'h80}, 1'b0, 1'b0, '0},
      '{'{11'd514, 16'h0000, 16'h8001, 16'hfffc, 8'h7f}, 1'b0, 1'b0, '0},
      '{'{11'd515, 16'h1001, 16'h0100, 16'h8001, 8'h3c}, 1'b0, 1'b0, '0},
      '{'{11'd515, 16'h0000, 16'hfe00, 16'h7ffe, 8'hc3}, 1'b0, 1'b0, '0},
      // touch the remaining motors
      '{'{11'd516, 16'haaaa, 16'h5555, 16'haaaa, 8'h55}, 1'b0, 1'b0, '0},
      '{'{11'd517, 16'h5555, 16'haaaa, 16'h5555, 8'haa}, 1'b0, 1'b0, '0},
      '{'{11'd518, 16'h8000, 16'h0080, 16'hff80, 8'h0f}, 1'b0, 1'b0, '0},
      '{'{11'd519, 16'h7fff, 16'h7f00, 16'h00ff, 8'hf0}, 1'b0, 1'b0, '0},
      // big jump up then back down on motor 0
      '{'{11'd513, 16'he001, 16'h0000, 16'h0000, 8'h00}, 1'b0, 1'b0, '0},
      '{'{11'd513, 16'h0000, 16'hffff, 16'hffff, 8'hff}, 1'b0, 1'b0, '0}
   };

   logic clock;
   logic reset = 1'b1;

   logic                       start        = 1'b0;
   logic                       busy;
   logic [10:0]                req_frame_id = '0;
   logic [7:0]                 req_byte0    = '0;
   logic [7:0]                 req_byte1    = '0;
   logic [7:0]                 req_byte2    = '0;
   logic [7:0]                 req_byte3    = '0;
   logic [7:0]                 req_byte4    = '0;
   logic [7:0]                 req_byte5    = '0;
   logic [7:0]                 req_byte6    = '0;

   logic                       rsp_valid;
   logic [SLOT_W-1:0]          rsp_motor_index;
   logic [ANGLE_W-1:0]         rsp_angle_now;
   logic signed [15:0]         rsp_measured_current;
   logic signed [CMD_W-1:0]    rsp_commanded_current;
   logic [7:0]                 rsp_hall_state;
   logic signed [TURNS_W-1:0]  rsp_turn_count;
   logic signed [TOTAL_W-1:0]  rsp_total_position;
   logic [FRAMES_W-1:0]        rsp_message_count;

   logic                       csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0]     csr_index = CSR_BASE_FRAME_ID;
   logic [CSR_DATA_W-1:0]      csr_wdata = '0;

   // Shadow of the register file and the per-motor table
   logic [10:0]         cfg_base   = BASE_FRAME_ID_RESET;
   logic [LIMIT_W-1:0]  cfg_active = ACTIVE_MOTORS_RESET;
   logic [15:0]         cfg_offset = '0;
   logic [ANGLE_W-1:0]  angle_shadow [MOTOR_SLOTS] = '{default: '0};
   logic [TURNS_W-1:0]  turn_tally  [MOTOR_SLOTS] = '{default: '0};
   logic [FRAMES_W-1:0] frame_tally [MOTOR_SLOTS] = '{default: '0};

   feedback_t expected_feedback [$];
   int        frames_decoded = 0;
   int        mismatches     = 0;
   int        quiet_cycles   = 0;

   motor_feedback_multiturn_decoder i_dut (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatches++;
      if (mismatches <= MAX_SHOWN)
         $display("%0t ns: %s got %0h, want %0h", $time, field, got, want);
   endtask

   // Decode one frame against the shadow table, update it, and return
   // whether the frame lands in the motor window.
   function automatic logic decode_frame(input frame_t f, output feedback_t r);
      int slot, window, a, prev, delta, t, cmd, off, pos;
      r = '0;
      if (f.id < cfg_base) return 1'b0;
      slot = f.id;
      slot = slot - cfg_base;
      window = (cfg_active < MOTOR_SLOTS) ? cfg_active : MOTOR_SLOTS;
      if (slot >= window) return 1'b0;

      a     = f.angle;
      prev  = angle_shadow[slot];
      delta = a - prev;
      t     = $signed(turn_tally[slot]);
      // A jump of more than half a turn is a wrap; saturate the count
      if (delta > HALF_TURN) begin
         if (t > -32768) t = t - 1;
      end else if (delta < -HALF_TURN) begin
         if (t < 32767) t = t + 1;
      end
      cmd = $signed(f.command);
      cmd = cmd / -5;
      off = cfg_offset;
      pos = t * (1 << TURN_SHIFT) + a - off;

      turn_tally[slot]   = t[TURNS_W-1:0];
      angle_shadow[slot] = f.angle;
      frame_tally[slot]  = frame_tally[slot] + 1;

      r.slot     = slot[SLOT_W-1:0];
      r.angle    = f.angle;
      r.current  = f.current;
      r.command  = cmd[CMD_W-1:0];
      r.hall     = f.hall;
      r.turns    = t[TURNS_W-1:0];
      r.position = pos[TOTAL_W-1:0];
      r.count    = frame_tally[slot];
      return 1'b1;
   endfunction

   function automatic logic [15:0] random_word();
      case ($urandom_range(0, 19))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'hffff;
         3: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   // Mostly frames for a motor in or just past the window, with angle
   // walks that cross the half-turn threshold; the rest is bus noise.
   function automatic frame_t random_frame();
      frame_t f;
      int pick, slot, base, step;
      base = cfg_base;
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
         slot = $urandom_range(0, 9);
         f.id = (base + slot > 2047) ? 11'($urandom) : 11'(base + slot);
      end else if (pick < 90 || base == 0) begin
         f.id = 11'($urandom);
      end else begin
         f.id = 11'($urandom_range(0, base - 1));
      end
      f.angle   = 16'($urandom);
      f.current = random_word();
      f.command = random_word();
      f.hall    = 8'($urandom);

      slot = f.id;
      slot = slot - base;
      if (slot >= 0 && slot < MOTOR_SLOTS) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            step = $urandom_range(0, 6000) - 3000;
         end else if (pick < 70) begin
            step = 4095 + $urandom_range(0, 2);
         end else begin
            step = $urandom_range(4098, 32767);
         end
         if (pick >= 50 && $urandom_range(0, 1) == 1) step = -step;
         // leave the remainder as fully random angles
         if (pick < 85) f.angle = angle_shadow[slot] + 16'(step);
      end
      return f;
   endfunction

   // Present one item and hold it until taken; drop start only ahead of a gap
   // so that back-to-back items keep start high.
   task automatic send_frame(input frame_t f, input int max_gap,
                             input logic pinned = 1'b0, input logic hit = 1'b0,
                             input feedback_t want = '0);
      int        gap;
      feedback_t modeled;
      logic      decoded;
      gap = $urandom_range(0, max_gap);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start        <= 1'b1;
      req_frame_id <= f.id;
      req_byte0    <= f.angle[15:8];
      req_byte1    <= f.angle[7:0];
      req_byte2    <= f.current[15:8];
      req_byte3    <= f.current[7:0];
      req_byte4    <= f.command[15:8];
      req_byte5    <= f.command[7:0];
      req_byte6    <= f.hall;
      do @(posedge clock); while (busy);
      decoded = decode_frame(f, modeled);
      if (pinned) begin
         if (hit) expected_feedback.push_back(want);
      end else if (decoded) begin
         expected_feedback.push_back(modeled);
      end
      if (decoded) frames_decoded++;
   endtask

   // Hold off until every response is in and the pipeline has emptied
   task automatic settle();
      start <= 1'b0;
      while (expected_feedback.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (index)
         CSR_BASE_FRAME_ID: cfg_base   = value[10:0];
         CSR_ACTIVE_MOTORS: cfg_active = value[LIMIT_W-1:0];
         CSR_ZERO_OFFSET:   cfg_offset = value;
         default: ;
      endcase
   endtask

   // Fill unused upper data bits with junk; the registers must ignore them
   task automatic configure(input logic [10:0] base, input logic [LIMIT_W-1:0] active,
                            input logic [15:0] offset);
      write_reg(CSR_BASE_FRAME_ID, {5'($urandom), base});
      write_reg(CSR_ACTIVE_MOTORS, {12'($urandom), active});
      write_reg(CSR_ZERO_OFFSET, offset);
   endtask

   // Check each response against the oldest pending item
   always @(posedge clock) begin : check_feedback
      feedback_t want;
      if (!reset && rsp_valid) begin
         if (expected_feedback.size() == 0) begin
            report_mismatch("unexpected response", 64'(rsp_motor_index), '0);
         end else begin
            want = expected_feedback.pop_front();
            if (rsp_motor_index !== want.slot)
               report_mismatch("motor_index", rsp_motor_index, want.slot);
            if (rsp_angle_now !== want.angle)
               report_mismatch("angle_now", rsp_angle_now, want.angle);
            if (rsp_measured_current !== want.current)
               report_mismatch("measured_current", rsp_measured_current, want.current);
            if (rsp_commanded_current !== want.command)
               report_mismatch("commanded_current", rsp_commanded_current, want.command);
            if (rsp_hall_state !== want.hall)
               report_mismatch("hall_state", rsp_hall_state, want.hall);
            if (rsp_turn_count !== want.turns)
               report_mismatch("turn_count", rsp_turn_count, want.turns);
            if (rsp_total_position !== want.position)
               report_mismatch("total_position", rsp_total_position, want.position);
            if (rsp_message_count !== want.count)
               report_mismatch("message_count", rsp_message_count, want.count);
         end
      end
   end

   // Watchdog: any accepted item, response or register write resets the count
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_motor_feedback_multiturn_decoder: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int     phase, sent, max_gap, k;
      frame_t f;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed rows at the reset settings
      foreach (DIRECTED_ROWS[i])
         send_frame(DIRECTED_ROWS[i].frame, 3, DIRECTED_ROWS[i].pinned,
                    DIRECTED_ROWS[i].hit, DIRECTED_ROWS[i].want);

      // Random phases; extremes first: window at 0 and at the top, no motors,
      // and motor counts past the table size
      for (phase = 0; phase < 10; phase++) begin
         settle();
         case (phase)
            0: configure(11'd0, 4'd1, 16'hffff);
            1: configure(11'd2047, 4'd8, 16'h0000);
            2: configure(11'd1000, 4'd0, 16'h8000);
            3: configure(11'd700, 4'd15, 16'h7fff);
            4: configure(11'd513, 4'd9, 16'h1234);
            default: configure(11'($urandom), 4'($urandom_range(1, 8)), 16'($urandom));
         endcase
         // alternate back-to-back, heavy gaps, and light gaps
         max_gap = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 19 : 4);
         frames_decoded = 0;
         for (sent = 0; sent < PHASE_CAP && frames_decoded < PHASE_HITS; sent++)
            send_frame(random_frame(), max_gap);
      end

      // Drive motor 0 down and motor 1 up over many turns. A step just over
      // half a turn counts a turn on every frame; the frame whose angle
      // wraps counts one back.
      settle();
      configure(11'd96, 4'd2, 16'($urandom));
      for (sent = 0; sent < SWEEP_FRAMES; sent++) begin
         k         = sent % 2;
         f.id      = 11'(96 + k);
         f.angle   = angle_shadow[k] + ((k == 0) ? 16'd4097 : 16'd61439);
         f.current = random_word();
         f.command = random_word();
         f.hall    = 8'($urandom);
         send_frame(f, 0);
      end

      settle();
      if (mismatches == 0) begin
         $display("tb_motor_feedback_multiturn_decoder: clean");
      end else begin
         $display("tb_motor_feedback_multiturn_decoder: errors");
      end
      $finish;
   end

endmodule
